### hw/rtl/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg: shared types, constants and helpers for the odometry block
// Holds the arctangent table, saturation helper and register indexes.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int unsigned MagW   = 64;
  localparam int unsigned MulW   = 32;
  localparam int unsigned ProdW  = MagW + MulW;
  localparam int unsigned CordW  = 34;

  localparam logic [31:0] AngleUnitsPerRad = 32'd683565276;
  localparam logic [31:0] CordicGain       = 32'd652032874;

  // Configuration register indexes
  localparam logic [1:0] RegTickDivide     = 2'd0;
  localparam logic [1:0] RegStepDistance   = 2'd1;
  localparam logic [1:0] RegReportInterval = 2'd2;
  localparam logic [1:0] RegInvTrackWidth  = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  // atan(2^-i) as a fraction of a full turn scaled by 2^32
  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Magnitude of a 64-bit two's complement value
  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Shift a magnitude product right, clamp to a signed width, apply sign
  function automatic logic [63:0] sat_scale(input logic neg, input logic [ProdW-1:0] prod,
                                            input logic [6:0] sh, input logic [6:0] bits);
    logic [ProdW-1:0] shv;
    logic [ProdW-1:0] lim;
    logic [ProdW-1:0] cap;
    shv = prod >> sh;
    lim = (ProdW'(1) << (bits - 7'd1)) - ProdW'(1);
    cap = neg ? (lim + ProdW'(1)) : lim;
    if (shv > cap) shv = cap;
    return neg ? (64'd0 - shv[63:0]) : shv[63:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ddo_mult.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_mult: shared 64x32 multiplier
// Builds the product from two 32x32 partial products, low then high half.
// ----------------------------------------------------------------------------
module ddo_mult
  import ddo_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [MagW-1:0]  mag_i,
  input  wire logic [MulW-1:0]  mul_i,
  output logic      [ProdW-1:0] prod_o,
  output unit_status_t          status_o
);

  logic [1:0]       cnt_q;
  logic             done_q;
  logic [MagW-1:0]  mag_q;
  logic [MulW-1:0]  mul_q;
  logic [63:0]      pp_q;
  logic [ProdW-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 2'd3);
      if (start_i) begin
        cnt_q <= 2'd1;
      end else if (cnt_q != 2'd0) begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_i;
      mul_q <= mul_i;
    end
    case (cnt_q)
      2'd1: pp_q <= mag_q[31:0] * mul_q;
      2'd2: begin
        acc_q <= {32'd0, pp_q};
        pp_q  <= mag_q[63:32] * mul_q;
      end
      2'd3: acc_q <= acc_q + {pp_q, 32'd0};
      default: ;
    endcase
  end

  assign prod_o        = acc_q;
  assign status_o.busy = (cnt_q != 2'd0);
  assign status_o.done = done_q;

endmodule
`default_nettype wire

### hw/rtl/ddo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_cordic: iterative rotation unit
// Gives cosine and sine of a binary angle, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ddo_cordic
  import ddo_pkg::*;
#(
  parameter int unsigned STEPS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic        [31:0]      angle_i,
  output logic signed      [CordW-1:0] cos_o,
  output logic signed      [CordW-1:0] sin_o,
  output unit_status_t                 status_o
);

  localparam int unsigned CntW = $clog2(STEPS + 1);

  logic                    busy_q;
  logic                    done_q;
  logic [CntW-1:0]         i_q;
  logic                    flip_q;
  logic signed [CordW-1:0] x_q;
  logic signed [CordW-1:0] y_q;
  logic signed [CordW-1:0] z_q;
  logic signed [CordW-1:0] xs;
  logic signed [CordW-1:0] ys;
  logic signed [CordW-1:0] at;
  logic                    flip;
  logic [31:0]             folded;

  assign flip   = angle_i[31] ^ angle_i[30];
  assign folded = angle_i ^ {flip, 31'd0};
  assign xs     = x_q >>> i_q;
  assign ys     = y_q >>> i_q;
  assign at     = signed'({2'b00, atan_turns(5'(i_q))});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (busy_q) begin
      if (i_q == CntW'(STEPS)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        i_q <= i_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= signed'({2'b00, CordicGain});
      y_q    <= '0;
      z_q    <= CordW'(signed'(folded));
      flip_q <= flip;
    end else if (busy_q && (i_q != CntW'(STEPS))) begin
      if (!z_q[CordW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign cos_o         = flip_q ? -x_q : x_q;
  assign sin_o         = flip_q ? -y_q : y_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule
`default_nettype wire

### hw/rtl/differential_drive_odometry.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_odometry: dead-reckoning pose tracker
// Counts wheel-speed ticks and integrates pose on every report tick.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one item per motor update tick on the s_axis channel. Most ticks
//   only advance the tick divider and are done in the cycle they are taken.
//   On every tick_divide-th tick the block runs ten scaling products through
//   one shared 64x32 multiplier (a load state and a multiply wait each) plus
//   a sum/difference state and an update state. Meanwhile s_axis_tready
//   stays low; the pose item appears on m_axis once the update is done, and
//   the next item can be taken in that same cycle, so reports never overlap.
//   The rotation unit computes cos/sin of the old heading alongside. The
//   finished pose waits in an output register; if the receiver stalls, the
//   next report holds in its final step until that register frees. Reset
//   clears pose, heading and tick count and loads the register defaults;
//   configuration writes go through cfg_*; the user must make them only while
//   the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS  = 16,
  parameter int unsigned POSITION_BITS = 48
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [20:0] left_wheel_rate, [41:21] right_wheel_rate, [47:42] zero
  input  wire logic [47:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [47:0] pose_x, [95:48] pose_y, [127:96] heading_angle,
  // [159:128] forward_velocity, [191:160] turn_rate
  output logic      [191:0] m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  localparam int unsigned PB = POSITION_BITS;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_CALC   = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;

  // Multiplier operations, in issue order
  localparam logic [3:0] OP_SL    = 4'd0;
  localparam logic [3:0] OP_SR    = 4'd1;
  localparam logic [3:0] OP_FWD   = 4'd2;
  localparam logic [3:0] OP_TURN  = 4'd3;
  localparam logic [3:0] OP_DIST  = 4'd4;
  localparam logic [3:0] OP_DDIST = 4'd5;
  localparam logic [3:0] OP_RAD   = 4'd6;
  localparam logic [3:0] OP_DANG  = 4'd7;
  localparam logic [3:0] OP_DX    = 4'd8;
  localparam logic [3:0] OP_DY    = 4'd9;

  // Configuration
  logic [15:0] tick_divide_q;
  logic [31:0] step_distance_q;
  logic [31:0] report_interval_q;
  logic [31:0] inv_track_q;

  // Architectural state
  logic [15:0]          tick_q;
  logic signed [PB-1:0] pos_x_q;
  logic signed [PB-1:0] pos_y_q;
  logic [31:0]          heading_q;

  // Sequencer and intermediates
  logic [2:0]  state_q;
  logic [3:0]  op_q;
  logic [20:0] left_q;
  logic [20:0] right_q;
  logic [63:0] sl_q, sr_q, sum_q, dif_q, dist_q, ddist_q, rad_q, dx_q, dy_q;
  logic [31:0] fwd_q, turn_q, dang_q;

  logic         out_valid_q;
  logic [191:0] out_q;

  // Shared units
  logic               mult_start;
  logic [MagW-1:0]    mag_sel;
  logic [MulW-1:0]    mul_sel;
  logic [ProdW-1:0]   prod;
  unit_status_t       mult_st;
  logic               cordic_start;
  logic signed [CordW-1:0] cos_v, sin_v;
  unit_status_t       cordic_st;

  logic        neg_sel;
  logic [6:0]  sh_sel;
  logic [6:0]  bits_sel;
  logic [63:0] sat_res;
  logic [63:0] cos_abs, sin_abs;

  logic        in_fire;
  logic [15:0] tick_inc, tick_next;
  logic        out_free;

  logic [PB:0]   sum_x, sum_y;
  logic [PB-1:0] new_x, new_y;
  logic [31:0]   new_heading;
  logic [63:0]   ext_x, ext_y;

  localparam logic [PB-1:0] PosMax = {1'b0, {(PB-1){1'b1}}};
  localparam logic [PB-1:0] PosMin = {1'b1, {(PB-1){1'b0}}};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign tick_inc      = tick_q + 16'd1;
  assign tick_next     = (tick_inc == tick_divide_q) ? 16'd0 : tick_inc;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign mult_start    = (state_q == ST_LOAD);
  assign cordic_start  = in_fire && (tick_next == 16'd0);

  assign cos_abs = abs64(64'(cos_v));
  assign sin_abs = abs64(64'(sin_v));

  // Operand, sign, shift and width for the current operation
  always_comb begin
    mag_sel  = '0;
    mul_sel  = '0;
    neg_sel  = 1'b0;
    sh_sel   = 7'd0;
    bits_sel = 7'd64;
    case (op_q)
      OP_SL: begin
        mag_sel = abs64(64'(signed'(left_q)));
        mul_sel = step_distance_q;
        neg_sel = left_q[20];
      end
      OP_SR: begin
        mag_sel = abs64(64'(signed'(right_q)));
        mul_sel = step_distance_q;
        neg_sel = right_q[20];
      end
      OP_FWD: begin
        mag_sel  = abs64(sum_q);
        mul_sel  = 32'd1;
        neg_sel  = sum_q[63];
        sh_sel   = 7'd17;
        bits_sel = 7'd32;
      end
      OP_TURN: begin
        mag_sel  = abs64(dif_q);
        mul_sel  = inv_track_q;
        neg_sel  = dif_q[63];
        sh_sel   = 7'd32;
        bits_sel = 7'd32;
      end
      OP_DIST: begin
        mag_sel  = abs64(sum_q);
        mul_sel  = report_interval_q;
        neg_sel  = sum_q[63];
        sh_sel   = 7'd33;
        bits_sel = 7'(PB);
      end
      OP_DDIST: begin
        mag_sel = abs64(dif_q);
        mul_sel = report_interval_q;
        neg_sel = dif_q[63];
        sh_sel  = 7'd16;
      end
      OP_RAD: begin
        mag_sel = abs64(ddist_q);
        mul_sel = inv_track_q;
        neg_sel = ddist_q[63];
        sh_sel  = 7'd16;
      end
      OP_DANG: begin
        mag_sel = rad_q;
        mul_sel = AngleUnitsPerRad;
      end
      OP_DX: begin
        mag_sel  = abs64(dist_q);
        mul_sel  = cos_abs[31:0];
        neg_sel  = dist_q[63] ^ cos_v[CordW-1];
        sh_sel   = 7'd30;
        bits_sel = 7'(PB);
      end
      OP_DY: begin
        mag_sel  = abs64(dist_q);
        mul_sel  = sin_abs[31:0];
        neg_sel  = dist_q[63] ^ sin_v[CordW-1];
        sh_sel   = 7'd30;
        bits_sel = 7'(PB);
      end
      default: ;
    endcase
  end

  assign sat_res = sat_scale(neg_sel, prod, sh_sel, bits_sel);

  // Saturating position update and heading wrap
  always_comb begin
    sum_x = {pos_x_q[PB-1], pos_x_q} + {dx_q[PB-1], dx_q[PB-1:0]};
    sum_y = {pos_y_q[PB-1], pos_y_q} + {dy_q[PB-1], dy_q[PB-1:0]};
    new_x = (sum_x[PB] != sum_x[PB-1]) ? (sum_x[PB] ? PosMin : PosMax) : sum_x[PB-1:0];
    new_y = (sum_y[PB] != sum_y[PB-1]) ? (sum_y[PB] ? PosMin : PosMax) : sum_y[PB-1:0];
    new_heading = heading_q + dang_q;
    ext_x = 64'(signed'(new_x));
    ext_y = 64'(signed'(new_y));
  end

  ddo_mult u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mult_start),
    .mag_i    (mag_sel),
    .mul_i    (mul_sel),
    .prod_o   (prod),
    .status_o (mult_st)
  );

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cordic_start),
    .angle_i  (heading_q),
    .cos_o    (cos_v),
    .sin_o    (sin_v),
    .status_o (cordic_st)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_divide_q     <= 16'd100;
      step_distance_q   <= 32'd0;
      report_interval_q <= 32'd6554;
      inv_track_q       <= 32'd163840;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegTickDivide:     tick_divide_q     <= cfg_data_i[15:0];
        RegStepDistance:   step_distance_q   <= cfg_data_i;
        RegReportInterval: report_interval_q <= cfg_data_i;
        RegInvTrackWidth:  inv_track_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_SL;
      tick_q      <= 16'd0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (m_axis_tready && !(state_q == ST_UPDATE && out_free)) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            tick_q <= tick_next;
            if (tick_next == 16'd0) begin
              op_q    <= OP_SL;
              state_q <= ST_LOAD;
            end
          end
        end
        ST_LOAD: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (mult_st.done) begin
            if (op_q == OP_SR) begin
              state_q <= ST_CALC;
            end else if (op_q == OP_DY) begin
              state_q <= ST_UPDATE;
            end else begin
              op_q    <= op_q + 4'd1;
              state_q <= ST_LOAD;
            end
          end
        end
        ST_CALC: begin
          op_q    <= OP_FWD;
          state_q <= ST_LOAD;
        end
        ST_UPDATE: begin
          // hold the finished report until the output register frees
          if (out_free) begin
            pos_x_q     <= new_x;
            pos_y_q     <= new_y;
            heading_q   <= new_heading;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      left_q  <= s_axis_tdata[20:0];
      right_q <= s_axis_tdata[41:21];
    end
    if (state_q == ST_CALC) begin
      sum_q <= sl_q + sr_q;
      dif_q <= sr_q - sl_q;
    end
    if (state_q == ST_WAIT && mult_st.done) begin
      case (op_q)
        OP_SL:    sl_q    <= sat_res;
        OP_SR:    sr_q    <= sat_res;
        OP_FWD:   fwd_q   <= sat_res[31:0];
        OP_TURN:  turn_q  <= sat_res[31:0];
        OP_DIST:  dist_q  <= sat_res;
        OP_DDIST: ddist_q <= sat_res;
        OP_RAD:   rad_q   <= sat_res;
        OP_DANG:  dang_q  <= prod[63:32];
        OP_DX:    dx_q    <= sat_res;
        OP_DY:    dy_q    <= sat_res;
        default: ;
      endcase
    end
    if (state_q == ST_UPDATE && out_free) begin
      out_q <= {turn_q, fwd_q, new_heading, ext_y[47:0], ext_x[47:0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Checks
  a_mult_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mult_st.busy && !mult_st.done)
    else $error("multiplier active while sequencer idle");

  a_cordic_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && (op_q == OP_DX || op_q == OP_DY)) |->
      cordic_st.done && !cordic_st.busy)
    else $error("rotation result used before it is ready");

  a_op_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (op_q <= OP_DY))
    else $error("operation index out of range");

  a_report_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && out_free) |=> m_axis_tvalid && (state_q == ST_IDLE))
    else $error("report not presented after pose update");

endmodule
`default_nettype wire
